// ===== hdl/svdps_pkg.sv =====
// Shared constants, types and arithmetic helpers for the SVD back-substitution solver.
package svdps_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int MAX_COLS  = 16;
    localparam int OUT_LIMIT = 16;
    localparam int ROW_LIM   = (MAX_ROWS < OUT_LIMIT) ? MAX_ROWS : OUT_LIMIT;
    localparam int COL_LIM   = (MAX_COLS < OUT_LIMIT) ? MAX_COLS : OUT_LIMIT;
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int UA_W      = $clog2(MAX_ROWS * MAX_COLS);
    localparam int VA_W      = $clog2(MAX_COLS * MAX_COLS);
    localparam int CNT_W     = 5;
    localparam int ADDR_W    = 4;

    // Register indexes (word address bits [3:2])
    localparam logic [1:0] REG_THRESH = 2'd0;
    localparam logic [1:0] REG_ROWS   = 2'd1;
    localparam logic [1:0] REG_COLS   = 2'd2;

    // Item kinds
    localparam logic [1:0] FN_U   = 2'd0;
    localparam logic [1:0] FN_V   = 2'd1;
    localparam logic [1:0] FN_W   = 2'd2;
    localparam logic [1:0] FN_RHS = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1_CHK,
        ST_P1_ISS,
        ST_P1_DRN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_P2_SETUP,
        ST_P2_ISS,
        ST_P2_DRN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [31:0] quot;
    } div_rsp_t;

    // Arithmetic shift right 16 of the accumulator, then saturate to 32 bits.
    function automatic logic signed [31:0] finish_acc(input logic signed [63:0] acc);
        logic signed [63:0] sh;
        begin
            sh = acc >>> 16;
            if (sh > 64'sh0000_0000_7FFF_FFFF) begin
                finish_acc = 32'sh7FFF_FFFF;
            end else if (sh < -64'sh0000_0000_8000_0000) begin
                finish_acc = -32'sh7FFF_FFFF - 32'sh1;
            end else begin
                finish_acc = sh[31:0];
            end
        end
    endfunction

    function automatic logic [CNT_W-1:0] clamp_size(input logic [4:0] v, input int lim);
        begin
            if (v == 5'd0) begin
                clamp_size = CNT_W'(1);
            end else if (int'(v) > lim) begin
                clamp_size = CNT_W'(lim);
            end else begin
                clamp_size = CNT_W'(v);
            end
        end
    endfunction

endpackage

// ===== hdl/svdps_mac.sv =====
// Shared multiply-accumulate unit: registered 32x32 product, 64-bit wrapping accumulator.
module svdps_mac
    import svdps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clr,
    input  logic               en,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] acc
);

    logic signed [63:0] prod_reg;
    logic               prod_vld_reg;
    logic signed [63:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= en;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (clr) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== hdl/svdps_div.sv =====
// Radix-2 restoring divider for (s << 16) / w, truncated toward zero and saturated.
module svdps_div
    import svdps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output div_rsp_t           rsp
);

    localparam int DV_W = 48;

    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [30:0]       rem_reg;
    logic [DV_W-1:0]   dvd_reg;
    logic [DV_W-1:0]   quo_reg;
    logic [30:0]       dsr_reg;
    logic              neg_reg;
    logic signed [31:0] res_reg;

    logic [31:0]       trial;
    logic              take;
    logic [31:0]       mag;
    logic [DV_W-1:0]   quo_next;

    assign mag      = num[31] ? (~num + 32'd1) : num;
    assign trial    = {rem_reg, dvd_reg[DV_W-1]};
    assign take     = trial >= {1'b0, dsr_reg};
    assign quo_next = {quo_reg[DV_W-2:0], take};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DV_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= {mag, 16'd0};
            quo_reg <= '0;
            dsr_reg <= den[30:0];
            neg_reg <= num[31];
        end else if (busy_reg) begin
            rem_reg <= take ? 31'(trial - {1'b0, dsr_reg}) : trial[30:0];
            dvd_reg <= {dvd_reg[DV_W-2:0], 1'b0};
            quo_reg <= quo_next;
            if (cnt_reg == 6'd0) begin
                if (!neg_reg) begin
                    res_reg <= (quo_next > DV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                                : quo_next[31:0];
                end else begin
                    res_reg <= (quo_next > DV_W'(32'h8000_0000)) ? 32'h8000_0000
                                                                : (~quo_next[31:0] + 32'd1);
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = res_reg;

endmodule

// ===== hdl/svd_pseudoinverse_solve_core.sv =====
// Top level: factor stores, APB registers, sequencer and result register of the solver.
//
// Load U, V and w entries one transfer each (func 0, 1, 2). A right-hand side element
// (func 3) is stored the same way; with last set it starts the solve, and the block drops
// s_ready until the final x element is transferred. The solve runs on one shared
// multiply-accumulate unit and one shift-subtract divider: per column with w above
// threshold, a projection and then a divide; a skipped column's result is set to zero.
// Then each x element is accumulated and held until the output is taken.
module svd_pseudoinverse_solve_core
    import svdps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [3:0]         s_row,
    input  logic [3:0]         s_col,
    input  logic signed [31:0] s_value,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_index,
    output logic signed [31:0] m_value_res,
    output logic               m_last_res
);

    logic [30:0]        thresh_reg;
    logic [4:0]         rows_reg;
    logic [4:0]         cols_reg;

    logic signed [31:0] u_mem  [MAX_ROWS*MAX_COLS];
    logic signed [31:0] v_mem  [MAX_COLS*MAX_COLS];
    logic signed [31:0] w_mem  [MAX_COLS];
    logic signed [31:0] b_mem  [MAX_ROWS];
    logic signed [31:0] sp_mem [MAX_COLS];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   i_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [1:0]         drn_reg;
    logic               iss_vld_reg;
    logic signed [31:0] u_q_reg;
    logic signed [31:0] v_q_reg;
    logic signed [31:0] vec_q_reg;
    logic signed [31:0] proj_reg;
    logic               m_valid_reg;
    logic [3:0]         m_index_reg;
    logic signed [31:0] m_value_reg;
    logic               m_last_reg;

    logic [CNT_W-1:0]   m_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               in_xfer;
    logic               cfg_wr;
    logic               w_keep;
    logic               i_last;
    logic               j_last;
    logic               phase2;
    logic               mac_clr;
    logic               div_start;
    logic [UA_W-1:0]    u_rd_addr;
    logic [VA_W-1:0]    v_rd_addr;
    logic signed [63:0] acc;
    logic signed [31:0] w_cur;
    div_rsp_t           div_rsp;

    // APB registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= '0;
            rows_reg   <= 5'd16;
            cols_reg   <= 5'd16;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_THRESH: thresh_reg <= pwdata[30:0];
                REG_ROWS:   rows_reg   <= pwdata[4:0];
                REG_COLS:   cols_reg   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_THRESH: prdata = {1'b0, thresh_reg};
            REG_ROWS:   prdata = {27'd0, rows_reg};
            REG_COLS:   prdata = {27'd0, cols_reg};
            default:    prdata = '0;
        endcase
    end

    assign m_cnt   = clamp_size(rows_reg, ROW_LIM);
    assign n_cnt   = clamp_size(cols_reg, COL_LIM);
    assign in_xfer = s_valid && s_ready;
    assign i_last  = (i_reg + CNT_W'(1)) == (phase2 ? n_cnt : m_cnt);
    assign j_last  = (j_reg + CNT_W'(1)) == n_cnt;
    assign phase2  = (state_reg == ST_P2_ISS) || (state_reg == ST_P2_DRN);
    assign w_cur   = w_mem[j_reg[COL_W-1:0]];
    assign w_keep  = !w_cur[31] && (w_cur[30:0] > thresh_reg);

    assign u_rd_addr = UA_W'(int'(i_reg) * MAX_COLS + int'(j_reg));
    assign v_rd_addr = VA_W'(int'(j_reg) * MAX_COLS + int'(i_reg));

    // Factor memories: one write port from the input channel, one registered read port
    always_ff @(posedge aclk) begin
        if (in_xfer && s_func == FN_U && int'(s_row) < MAX_ROWS && int'(s_col) < MAX_COLS) begin
            u_mem[UA_W'(int'(s_row) * MAX_COLS + int'(s_col))] <= s_value;
        end
        u_q_reg <= u_mem[u_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_func == FN_V && int'(s_row) < MAX_COLS && int'(s_col) < MAX_COLS) begin
            v_mem[VA_W'(int'(s_row) * MAX_COLS + int'(s_col))] <= s_value;
        end
        v_q_reg <= v_mem[v_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_func == FN_W && int'(s_row) < MAX_COLS) begin
            w_mem[COL_W'(s_row)] <= s_value;
        end
        if (in_xfer && s_func == FN_RHS && int'(s_row) < MAX_ROWS) begin
            b_mem[ROW_W'(s_row)] <= s_value;
        end
        if (state_reg == ST_P1_CHK && !w_keep) begin
            sp_mem[j_reg[COL_W-1:0]] <= '0;
        end else if (state_reg == ST_DIV_WAIT && div_rsp.done) begin
            sp_mem[j_reg[COL_W-1:0]] <= div_rsp.quot;
        end
        vec_q_reg <= (state_reg == ST_P2_ISS) ? sp_mem[i_reg[COL_W-1:0]]
                                              : b_mem[i_reg[ROW_W-1:0]];
    end

    svdps_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (mac_clr),
        .en      (iss_vld_reg),
        .op_a    (phase2 ? v_q_reg : u_q_reg),
        .op_b    (vec_q_reg),
        .acc     (acc)
    );

    svdps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (proj_reg),
        .den     (w_cur),
        .rsp     (div_rsp)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && s_func == FN_RHS && s_last) state_next = ST_P1_CHK;
            end
            ST_P1_CHK: begin
                if (w_keep) state_next = ST_P1_ISS;
                else if (j_last) state_next = ST_P2_SETUP;
            end
            ST_P1_ISS: begin
                if (i_last) state_next = ST_P1_DRN;
            end
            ST_P1_DRN: begin
                if (drn_reg == 2'd2) state_next = ST_DIV_GO;
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp.done) state_next = j_last ? ST_P2_SETUP : ST_P1_CHK;
            end
            ST_P2_SETUP: state_next = ST_P2_ISS;
            ST_P2_ISS: begin
                if (i_last) state_next = ST_P2_DRN;
            end
            ST_P2_DRN: begin
                if (drn_reg == 2'd2) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = j_last ? ST_IDLE : ST_P2_SETUP;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        mac_clr   = (state_reg == ST_P1_CHK) || (state_reg == ST_P2_SETUP);
        div_start = (state_reg == ST_DIV_GO);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            drn_reg     <= '0;
            iss_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iss_vld_reg <= (state_reg == ST_P1_ISS) || (state_reg == ST_P2_ISS);
            unique case (state_reg)
                ST_IDLE: begin
                    j_reg <= '0;
                    i_reg <= '0;
                end
                ST_P1_CHK: begin
                    i_reg   <= '0;
                    drn_reg <= '0;
                    if (!w_keep) j_reg <= j_last ? '0 : j_reg + CNT_W'(1);
                end
                ST_P1_ISS, ST_P2_ISS: begin
                    i_reg <= i_reg + CNT_W'(1);
                end
                ST_P1_DRN, ST_P2_DRN: begin
                    drn_reg <= drn_reg + 2'd1;
                    if (drn_reg == 2'd2 && state_reg == ST_P2_DRN) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_rsp.done) j_reg <= j_last ? '0 : j_reg + CNT_W'(1);
                end
                ST_P2_SETUP: begin
                    i_reg   <= '0;
                    drn_reg <= '0;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        j_reg       <= j_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload captures
    always_ff @(posedge aclk) begin
        if (state_reg == ST_P1_DRN && drn_reg == 2'd2) begin
            proj_reg <= finish_acc(acc);
        end
        if (state_reg == ST_P2_DRN && drn_reg == 2'd2) begin
            m_index_reg <= j_reg[3:0];
            m_value_reg <= finish_acc(acc);
            m_last_reg  <= j_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_index     = m_index_reg;
    assign m_value_res = m_value_reg;
    assign m_last_res  = m_last_reg;

    a_out_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !s_ready)
        else $error("input accepted while a result is pending");

    a_out_only_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == ST_OUT))
        else $error("result valid outside output state");

    a_div_idle_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while idle");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside wait state");

endmodule
